### src/rfgs_pkg.sv
// rfgs_pkg: shared types and codes for the rectangle fill / gradient / shadow shader
// no dependencies; imported by rect_fill_gradient_shadow_shader_core
`default_nettype none

package rfgs_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_RECT_X      = 3'd1;
  localparam logic [2:0] REG_RECT_Y      = 3'd2;
  localparam logic [2:0] REG_RECT_W      = 3'd3;
  localparam logic [2:0] REG_RECT_H      = 3'd4;
  localparam logic [2:0] REG_COLOR_START = 3'd5;
  localparam logic [2:0] REG_COLOR_END   = 3'd6;

  // fill modes
  localparam logic [1:0] MODE_SOLID  = 2'd0;
  localparam logic [1:0] MODE_HGRAD  = 2'd1;
  localparam logic [1:0] MODE_VGRAD  = 2'd2;
  localparam logic [1:0] MODE_SHADOW = 2'd3;

  // color layout
  localparam int NumChan  = 3;
  localparam int ChanW    = 8;
  localparam int QuotW    = 8;
  // divider datapath: 8-bit span times 12-bit offset, plus headroom
  localparam int DivW     = 21;
  localparam int DivStages = 4;

  // sideband that travels with a pixel down the pipe
  typedef struct packed {
    logic        we;
    logic        grad;
    logic [31:0] pix;
    logic [2:0]  neg;
  } ctl_t;

endpackage

`default_nettype wire

### src/rect_fill_gradient_shadow_shader_core.sv
// rect_fill_gradient_shadow_shader_core: per-pixel rectangle shader, pipelined
// depends on rfgs_pkg (codes, widths, sideband struct)
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+------------------------------
//  pixel in  | pixel_col, pixel_row, old_pixel           | taken when start & !busy
//  result    | write_enable, new_pixel                   | done high for one cycle
//  config    | cfg_idx, cfg_data                         | written when cfg_we
//
// one pixel per clock while busy is low; a taken pixel passes the setup stage,
// multiply stage, four divide stages at two quotient bits each and the output
// register; the gradient divide sets the depth
// rst is synchronous; busy is high during reset and the cycle after it
// the receiver cannot stall, so the pipe advances every cycle
`default_nettype none

module rect_fill_gradient_shadow_shader_core
  import rfgs_pkg::*;
#(
  parameter int SCREEN_W = 1024,
  parameter int SCREEN_H = 768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [11:0] pixel_col,
  input  wire logic [11:0] pixel_row,
  input  wire logic [31:0] old_pixel,
  output logic             done,
  output logic             write_enable,
  output logic [31:0]      new_pixel,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [31:0] cfg_data
);

  localparam logic [12:0] ScrW = 13'(SCREEN_W);
  localparam logic [12:0] ScrH = 13'(SCREEN_H);

  // configuration registers
  logic [1:0]  mode;
  logic [11:0] rect_x;
  logic [11:0] rect_y;
  logic [12:0] rect_w;
  logic [12:0] rect_h;
  logic [31:0] color_start;
  logic [31:0] color_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SOLID;
      rect_x      <= '0;
      rect_y      <= '0;
      rect_w      <= '0;
      rect_h      <= '0;
      color_start <= '0;
      color_end   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:        mode        <= cfg_data[1:0];
        REG_RECT_X:      rect_x      <= cfg_data[11:0];
        REG_RECT_Y:      rect_y      <= cfg_data[11:0];
        REG_RECT_W:      rect_w      <= cfg_data[12:0];
        REG_RECT_H:      rect_h      <= cfg_data[12:0];
        REG_COLOR_START: color_start <= cfg_data;
        REG_COLOR_END:   color_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy only around reset; the pipe never holds off input
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start & ~busy;

  // gradient divisor; the user must keep it stable while pixels are in flight, the block does not enforce it
  logic [12:0] total_sel;
  assign total_sel = (mode == MODE_VGRAD) ? rect_h : rect_w;

  // ---------------- stage 1: clip test, offsets, channel spans
  logic [11:0] dx, dy, t_sel;
  logic        in_x, in_y, in_rect, shade_hit, we_s1;
  logic [13:0] x_end, y_end;
  logic [2:0]  neg_s1;
  logic [ChanW-1:0] mag_s1 [NumChan];
  logic [31:0] direct_pix;

  always_comb begin
    dx    = pixel_col - rect_x;
    dy    = pixel_row - rect_y;
    x_end = {2'b00, rect_x} + {1'b0, rect_w};
    y_end = {2'b00, rect_y} + {1'b0, rect_h};
    in_x  = (pixel_col >= rect_x) && ({2'b00, pixel_col} < x_end) &&
            ({1'b0, pixel_col} < ScrW);
    in_y  = (pixel_row >= rect_y) && ({2'b00, pixel_row} < y_end) &&
            ({1'b0, pixel_row} < ScrH);
    in_rect = in_x & in_y;
    t_sel  = (mode == MODE_VGRAD) ? dy : dx;
    // shadow: near the top or left edge, or odd checkerboard square
    shade_hit = (dx < 12'd2) || (dy < 12'd2) || (pixel_col[0] ^ pixel_row[0]);
    we_s1 = in_rect && ((mode != MODE_SHADOW) || shade_hit);
    for (int c = 0; c < NumChan; c++) begin
      neg_s1[c] = color_end[c*ChanW +: ChanW] < color_start[c*ChanW +: ChanW];
      mag_s1[c] = neg_s1[c] ?
                  color_start[c*ChanW +: ChanW] - color_end[c*ChanW +: ChanW] :
                  color_end[c*ChanW +: ChanW] - color_start[c*ChanW +: ChanW];
    end
    // solid passes all 32 bits; shadow halves each channel
    if (mode == MODE_SHADOW) begin
      direct_pix = {8'h00, 1'b0, old_pixel[23:17], 1'b0, old_pixel[15:9],
                    1'b0, old_pixel[7:1]};
    end else begin
      direct_pix = color_start;
    end
  end

  logic             v1;
  ctl_t             ctl1;
  logic [11:0]      t1;
  logic [ChanW-1:0] mag1 [NumChan];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ctl1.we   <= we_s1;
    ctl1.grad <= (mode == MODE_HGRAD) || (mode == MODE_VGRAD);
    ctl1.pix  <= direct_pix;
    ctl1.neg  <= neg_s1;
    t1        <= t_sel;
    for (int c = 0; c < NumChan; c++) begin
      mag1[c] <= mag_s1[c];
    end
  end

  // ---------------- stage 2: span times offset
  logic            vd   [DivStages+1];
  ctl_t            ctld [DivStages+1];
  logic [DivW-1:0] rem  [DivStages+1][NumChan];
  logic [QuotW-1:0] quo [DivStages+1][NumChan];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else begin
      vd[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ctld[0] <= ctl1;
    for (int c = 0; c < NumChan; c++) begin
      rem[0][c] <= DivW'(mag1[c]) * DivW'(t1);
      quo[0][c] <= '0;
    end
  end

  // ---------------- divide stages: two restoring steps each
  // inside the rectangle t < total, so the quotient fits in eight bits
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    localparam int KHi = QuotW - 1 - 2*s;
    localparam int KLo = QuotW - 2 - 2*s;
    logic [DivW-1:0]  dv_hi, dv_lo;
    logic [DivW-1:0]  rem_n [NumChan];
    logic [QuotW-1:0] quo_n [NumChan];

    assign dv_hi = DivW'(total_sel) << KHi;
    assign dv_lo = DivW'(total_sel) << KLo;

    always_comb begin
      for (int c = 0; c < NumChan; c++) begin
        rem_n[c] = rem[s][c];
        quo_n[c] = quo[s][c];
        if (rem_n[c] >= dv_hi) begin
          rem_n[c]      = rem_n[c] - dv_hi;
          quo_n[c][KHi] = 1'b1;
        end
        if (rem_n[c] >= dv_lo) begin
          rem_n[c]      = rem_n[c] - dv_lo;
          quo_n[c][KLo] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s+1] <= 1'b0;
      end else begin
        vd[s+1] <= vd[s];
      end
    end

    always_ff @(posedge clk) begin
      ctld[s+1] <= ctld[s];
      for (int c = 0; c < NumChan; c++) begin
        rem[s+1][c] <= rem_n[c];
        quo[s+1][c] <= quo_n[c];
      end
    end
  end

  // ---------------- output stage: apply sign, pick result
  logic [ChanW-1:0] chan_out [NumChan];
  logic [31:0]      pix_sel;
  ctl_t             ctl_last;

  assign ctl_last = ctld[DivStages];

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      chan_out[c] = ctl_last.neg[c] ?
                    color_start[c*ChanW +: ChanW] - quo[DivStages][c] :
                    color_start[c*ChanW +: ChanW] + quo[DivStages][c];
    end
    if (ctl_last.grad) begin
      pix_sel = {8'h00, chan_out[2], chan_out[1], chan_out[0]};
    end else begin
      pix_sel = ctl_last.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    write_enable <= ctl_last.we;
    new_pixel    <= ctl_last.we ? pix_sel : 32'h0;
  end

endmodule

`default_nettype wire
